@@ hw/rtl/bistk_pkg.sv @@
// Shared types and constants for the bounded integer stack.
package bistk_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int FIELD_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WORD = 1'd1;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_POPD  = 2'd2,
    FUNC_COUNT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_PUSH_FULL = 2'd1,
    ERR_POP_EMPTY = 2'd2
  } err_t;

  typedef struct packed {
    func_t                     func;
    logic signed [WORD_W-1:0]  item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  popped_word;
    logic [FIELD_W-1:0]        match_count;
    logic [FIELD_W-1:0]        fill_level;
    logic                      now_empty;
    logic                      now_full;
    err_t                      error_code;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic push;
    logic pop;
    logic scan_rd;
    logic scan_cmp;
    logic finish;
  } bistk_cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_t func;
    logic  empty;
    logic  scan_done;
  } bistk_sts_t;

endpackage

@@ hw/rtl/bistk_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bistk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/bistk_ctrl.sv @@
// Sequencing state machine for the stack: decode, scan loop, result handoff.
module bistk_ctrl
  import bistk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  bistk_sts_t sts,
  output bistk_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN,
    S_OUT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.func)
          FUNC_PUSH: begin
            cmd.push = 1'b1;
            state_next = S_FIN;
          end
          FUNC_POP, FUNC_POPD: begin
            cmd.pop = 1'b1;
            state_next = S_FIN;
          end
          FUNC_COUNT: begin
            if (sts.empty) begin
              state_next = S_FIN;
            end else begin
              cmd.scan_rd = 1'b1;
              state_next = S_SCAN;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_SCAN: begin
        // read data of the previous address is compared while the next is fetched
        cmd.scan_cmp = 1'b1;
        if (sts.scan_done) begin
          state_next = S_FIN;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      in_ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      in_ready <= (state_next == S_IDLE);
      out_valid <= (state_next == S_OUT);
    end
  end

endmodule

@@ hw/rtl/bistk_dp.sv @@
// Stack datapath: fill count, storage, scan counter, config and result registers.
module bistk_dp
  import bistk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0]     cfg_wdata,
  input  in_item_t              in_data,
  input  bistk_cmd_t            cmd,
  output bistk_sts_t            sts,
  output out_item_t             out_data
);

  logic [CNT_W-1:0]         top;
  logic                     default_enable;
  logic signed [WORD_W-1:0] default_word;

  func_t                    func_q;
  logic signed [WORD_W-1:0] val_q;
  logic [CNT_W-1:0]         scan_idx;
  logic [CNT_W-1:0]         match_q;
  logic signed [WORD_W-1:0] popped_q;
  logic                     from_ram;
  err_t                     err_q;
  out_item_t                res_q;

  logic                     empty, full;
  logic                     ram_we, ram_rd;
  logic [PTR_W-1:0]         ram_waddr, ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;

  assign empty = (top == '0);
  assign full  = (top == CNT_W'(DEPTH));

  assign ram_we    = cmd.push && !full;
  assign ram_waddr = PTR_W'(top);
  assign ram_rd    = (cmd.pop && !empty) || cmd.scan_rd;
  assign ram_raddr = cmd.pop ? PTR_W'(top - CNT_W'(1)) : PTR_W'(scan_idx);

  bistk_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_q),
    .rd_en (ram_rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
      default_enable <= 1'b0;
      default_word <= '0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_DEFAULT_ENABLE: default_enable <= cfg_wdata[0];
          CFG_DEFAULT_WORD:   default_word <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.push && !full) begin
        top <= top + CNT_W'(1);
      end else if (cmd.pop && !empty) begin
        top <= top - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= in_data.func;
      val_q <= in_data.item_value;
      scan_idx <= '0;
      match_q <= '0;
      popped_q <= '0;
      from_ram <= 1'b0;
      err_q <= ERR_NONE;
    end
    if (cmd.push && full) begin
      err_q <= ERR_PUSH_FULL;
    end
    if (cmd.pop) begin
      if (!empty) begin
        from_ram <= 1'b1;
      end else if (func_q == FUNC_POPD) begin
        popped_q <= val_q;
      end else if (default_enable) begin
        popped_q <= default_word;
      end else begin
        err_q <= ERR_POP_EMPTY;
      end
    end
    if (cmd.scan_rd) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if (cmd.scan_cmp && (ram_rdata == val_q)) begin
      match_q <= match_q + CNT_W'(1);
    end
    if (cmd.finish) begin
      res_q.popped_word <= from_ram ? ram_rdata : popped_q;
      res_q.match_count <= FIELD_W'(match_q);
      res_q.fill_level <= FIELD_W'(top);
      res_q.now_empty <= empty;
      res_q.now_full <= full;
      res_q.error_code <= err_q;
    end
  end

  assign sts.func      = func_q;
  assign sts.empty     = empty;
  assign sts.scan_done = (scan_idx == top);
  assign out_data      = res_q;

  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    top <= CNT_W'(DEPTH))
    else $error("fill count beyond capacity");

  a_top_hold: assert property (@(posedge clk) disable iff (rst)
    (!cmd.push && !cmd.pop) || (cmd.push && full) |=> $stable(top))
    else $error("fill count moved without a push or pop");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |-> (scan_idx < top))
    else $error("scan read outside filled region");

  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && (err_q == ERR_POP_EMPTY) |-> empty)
    else $error("pop error reported on a nonempty stack");

endmodule

@@ hw/rtl/bounded_int_stack_with_default.sv @@
// Each beat steps through execute, finish and output states before out_valid rises;
// a count on a nonempty stack adds a scan state that runs until every filled entry is compared.
// Count walks the filled entries through the single read port of the stack RAM, one a cycle.
// A result waits in the output register until its beat is taken; then the next beat is accepted.
// Reset clears the fill count, the sequencer and both config registers; RAM contents are kept.
module bounded_int_stack_with_default
  import bistk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  bistk_cmd_t cmd;
  bistk_sts_t sts;

  bistk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bistk_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_data      (in_data),
    .cmd          (cmd),
    .sts          (sts),
    .out_data     (out_data)
  );

endmodule

@@ test/tb_bounded_int_stack_with_default.sv @@
// Testbench for bounded_int_stack_with_default: random ops checked against a shadow stack.
module tb_bounded_int_stack_with_default;
  import bistk_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;

  bounded_int_stack_with_default dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // shadow of the stack and its registers
  logic signed [WORD_W-1:0] shadow_words [DEPTH];
  int                       shadow_fill = 0;
  logic                     dflt_on = 1'b0;
  logic signed [WORD_W-1:0] dflt_val = '0;

  in_item_t  pending_ops[$];
  out_item_t expected_results[$];
  int        mismatches = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  bit        no_idle = 1'b0;

  initial forever #1 clk = ~clk;

  initial begin
    #1600000;
    $display("tb_bounded_int_stack_with_default NOT OK");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Applies one op to the shadow stack and returns the result it must produce.
  function automatic out_item_t stack_apply(in_item_t op);
    out_item_t r;
    int        hits;
    r = '0;
    r.error_code = ERR_NONE;
    hits = 0;
    case (op.func)
      FUNC_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          r.error_code = ERR_PUSH_FULL;
        end else begin
          shadow_words[shadow_fill] = op.item_value;
          shadow_fill++;
        end
      end
      FUNC_POP, FUNC_POPD: begin
        if (shadow_fill > 0) begin
          shadow_fill--;
          r.popped_word = shadow_words[shadow_fill];
        end else if (op.func == FUNC_POPD) begin
          r.popped_word = op.item_value;
        end else if (dflt_on) begin
          r.popped_word = dflt_val;
        end else begin
          r.error_code = ERR_POP_EMPTY;
        end
      end
      default: begin
        for (int i = 0; i < shadow_fill; i++)
          if (shadow_words[i] == op.item_value) hits++;
      end
    endcase
    r.match_count = FIELD_W'(hits);
    r.fill_level  = FIELD_W'(shadow_fill);
    r.now_empty   = (shadow_fill == 0);
    r.now_full    = (shadow_fill >= DEPTH);
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      flag_mismatch("result beat with nothing pending, fill_level", got.fill_level, 0);
    end else begin
      want = expected_results.pop_front();
      if (got.popped_word !== want.popped_word)
        flag_mismatch("popped_word", got.popped_word, want.popped_word);
      if (got.match_count !== want.match_count)
        flag_mismatch("match_count", got.match_count, want.match_count);
      if (got.fill_level !== want.fill_level)
        flag_mismatch("fill_level", got.fill_level, want.fill_level);
      if (got.now_empty !== want.now_empty)
        flag_mismatch("now_empty", got.now_empty, want.now_empty);
      if (got.now_full !== want.now_full)
        flag_mismatch("now_full", got.now_full, want.now_full);
      if (got.error_code !== want.error_code)
        flag_mismatch("error_code", got.error_code, want.error_code);
    end
  endtask

  // driver: the beat accepted at this edge is predicted before the next one goes out
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(), stack_apply(in_data));
      if (in_valid && !in_ready) begin
        // hold the beat
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_ops.size() != 0) begin
        in_data  <= pending_ops.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and result-side backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) stall_left <= pick_gap();
      end
    end
  end

  task automatic queue_op(func_t f, logic [WORD_W-1:0] v);
    in_item_t it;
    it.func = f;
    it.item_value = v;
    pending_ops.insert(pending_ops.size(), it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_wdata    <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == CFG_DEFAULT_ENABLE) dflt_on = data[0];
    else dflt_val = data;
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // mode 0 fills, 1 drains, 2 mixes, 3 fills with one repeated word
  function automatic in_item_t make_item(int mode, logic [WORD_W-1:0] hot);
    in_item_t it;
    int       push_pct;
    case (mode)
      0: push_pct = 75;
      1: push_pct = 20;
      2: push_pct = 45;
      default: push_pct = 80;
    endcase
    if ($urandom_range(0, 99) < push_pct) it.func = FUNC_PUSH;
    else it.func = func_t'($urandom_range(1, 3));
    if (mode == 3 && it.func != FUNC_POPD) begin
      it.item_value = hot;
    end else begin
      case ($urandom_range(0, 9))
        0: it.item_value = 32'h8000_0000;
        1: it.item_value = 32'h7FFF_FFFF;
        2: it.item_value = '0;
        3, 4, 5: it.item_value = hot;
        default: it.item_value = $urandom;
      endcase
    end
    return it;
  endfunction

  initial begin
    int               mode;
    logic [WORD_W-1:0] hot;
    mode = 0;
    hot = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty-stack cases with the default off, fill to the limit, overflow, count
    queue_op(FUNC_POP, 32'h1234_5678);
    queue_op(FUNC_POPD, 32'h8000_0000);
    queue_op(FUNC_COUNT, 32'h0);
    queue_op(FUNC_PUSH, 32'h8000_0000);
    repeat (DEPTH - 1) queue_op(FUNC_PUSH, 32'hFFFF_FFFF);
    queue_op(FUNC_PUSH, 32'h5);
    queue_op(FUNC_COUNT, 32'hFFFF_FFFF);
    queue_op(FUNC_COUNT, 32'h8000_0000);
    queue_op(FUNC_POPD, 32'h7);
    queue_op(FUNC_POP, 32'h7FFF_FFFF);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_DEFAULT_ENABLE, 32'h1);
          write_reg(CFG_DEFAULT_WORD, 32'h8000_0000);
        end
        1: write_reg(CFG_DEFAULT_WORD, 32'h7FFF_FFFF);
        2: begin
          write_reg(CFG_DEFAULT_ENABLE, {$urandom} & ~32'h1);
          write_reg(CFG_DEFAULT_WORD, $urandom);
        end
        3: begin
          write_reg(CFG_DEFAULT_ENABLE, {$urandom} | 32'h1);
          write_reg(CFG_DEFAULT_WORD, 32'h0);
        end
        4: write_reg(CFG_DEFAULT_WORD, $urandom);
        default: begin
          write_reg(CFG_DEFAULT_ENABLE, 32'hFFFF_FFFE);
          write_reg(CFG_DEFAULT_WORD, 32'hFFFF_FFFF);
        end
      endcase
      no_idle = (ph == 2);
      for (int k = 0; k < 250; k++) begin
        if (k % 24 == 0) begin
          mode = $urandom_range(0, 3);
          hot = $urandom;
        end
        pending_ops.insert(pending_ops.size(), make_item(mode, hot));
      end
      drain();
    end

    repeat (25) @(posedge clk);
    if (mismatches == 0)
      $display("tb_bounded_int_stack_with_default OK");
    else
      $display("tb_bounded_int_stack_with_default NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/bistk_pkg.sv
hw/rtl/bistk_ram.sv
hw/rtl/bistk_ctrl.sv
hw/rtl/bistk_dp.sv
hw/rtl/bounded_int_stack_with_default.sv
test/tb_bounded_int_stack_with_default.sv
